// ===== rtl/core/tgzc_pkg.sv =====
// Shared types and constants for the touch gesture and zone classifier.
package tgzc_pkg;

   // Configuration register indexes.
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] REG_MIN_GAP       = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_HOLD_TIME     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_CIRCLE_CENTER = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_CIRCLE_RADIUS = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_EDGE_LOW      = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_EDGE_HIGH     = 3'd5;

   // Register values after reset.
   localparam logic [15:0] MIN_GAP_RESET       = 16'd100;
   localparam logic [15:0] HOLD_TIME_RESET     = 16'd1500;
   localparam logic [11:0] CIRCLE_CENTER_RESET = 12'd233;
   localparam logic [11:0] CIRCLE_RADIUS_RESET = 12'd233;
   localparam logic [11:0] EDGE_LOW_RESET      = 12'd140;
   localparam logic [11:0] EDGE_HIGH_RESET     = 12'd326;

   // Gesture bytes reported by the touch controller.
   localparam logic [7:0] CODE_DOUBLE = 8'h0B;
   localparam logic [7:0] CODE_UP     = 8'h02;
   localparam logic [7:0] CODE_DOWN   = 8'h01;

   // Event gestures.
   localparam logic [2:0] GEST_TAP      = 3'd0;
   localparam logic [2:0] GEST_DOUBLE   = 3'd1;
   localparam logic [2:0] GEST_LONG     = 3'd2;
   localparam logic [2:0] GEST_LONG_REL = 3'd3;
   localparam logic [2:0] GEST_UP       = 3'd4;
   localparam logic [2:0] GEST_DOWN     = 3'd5;
   localparam logic [2:0] GEST_TWO      = 3'd6;

   // Screen zones.
   localparam logic [2:0] ZONE_OUTSIDE = 3'd0;
   localparam logic [2:0] ZONE_TOP     = 3'd1;
   localparam logic [2:0] ZONE_BOTTOM  = 3'd2;
   localparam logic [2:0] ZONE_LEFT    = 3'd3;
   localparam logic [2:0] ZONE_RIGHT   = 3'd4;
   localparam logic [2:0] ZONE_FACE    = 3'd5;

   typedef struct packed {
      logic [7:0]  gesture_code;
      logic [7:0]  finger_count;
      logic [1:0]  event_kind;
      logic [11:0] x_pos;
      logic [11:0] y_pos;
      logic [31:0] now_ms;
   } tgzc_req_type;

   typedef struct packed {
      logic [2:0]  event_gesture;
      logic [2:0]  event_zone;
      logic [11:0] event_x;
      logic [11:0] event_y;
   } tgzc_rsp_type;

   typedef struct packed {
      logic [15:0] min_gap;
      logic [15:0] hold_time;
      logic [11:0] circle_center;
      logic [11:0] circle_radius;
      logic [11:0] edge_low;
      logic [11:0] edge_high;
   } tgzc_cfg_type;

   // A dispatched event before its zone is known.
   typedef struct packed {
      logic [2:0]  gesture;
      logic [11:0] x;
      logic [11:0] y;
   } tgzc_event_type;

endpackage

// ===== rtl/core/touch_gesture_zone_classifier.sv =====
// Top level of the touch gesture and zone classifier.
//
// The block takes one decoded touch-controller report per item and turns the
// stream of reports into gesture events: tap, double tap, swipe up or down,
// long press, long-press release and two-finger tap. It can accept one item in
// every clock cycle while the rsp channel does not stall; an item that produces
// an event passes the event register, the squaring register and the result
// register after the input register before its result shows on the rsp
// channel, and the press-tracking state is updated as an item leaves the input
// register, so the next item sees it at once. Many items produce no event,
// and nothing comes out for them. Each event carries a screen zone: outside
// when the point lies outside the configured circle (a point on the circle
// counts as inside), otherwise top, bottom, left or right from strict
// compares against edge_low and edge_high, checked in that order, or face
// center. Events closer than the configured debounce time to the previously
// dispatched event are dropped, except long-press release; all time
// differences wrap modulo 2^32. The event kind field of a report is carried
// but does not affect the outcome. Registers are written through the csr
// port, which is always ready; unknown indexes are ignored, and registers
// should only be written while the block is idle.
module touch_gesture_zone_classifier import tgzc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tgzc_req_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tgzc_rsp_type             rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   // Configuration registers.
   tgzc_cfg_type   cfg_ff;

   // Input register.
   logic           s0_valid_ff;
   logic           s0_valid_in;
   tgzc_req_type   s0_req_ff;
   logic           s0_ready;
   logic           s0_fire;

   // Event register feeding the zone lookup.
   logic           s1_valid_ff;
   logic           s1_valid_in;
   tgzc_event_type s1_event_ff;
   logic           s1_ready;
   logic           zone_ready;

   // Press-tracking state.
   logic           finger_down_ff;
   logic           finger_down_in;
   logic [31:0]    press_start_time_ff;
   logic [31:0]    press_start_time_in;
   logic [11:0]    press_start_x_ff;
   logic [11:0]    press_start_x_in;
   logic [11:0]    press_start_y_ff;
   logic [11:0]    press_start_y_in;
   logic           long_done_ff;
   logic           long_done_in;
   logic [31:0]    last_dispatch_ff;
   logic [31:0]    last_dispatch_in;

   logic           fingers_present;
   logic           multi_finger;
   logic [31:0]    held_ms;
   logic [31:0]    since_ms;
   logic           long_due;
   logic           debounce_ok;
   logic           candidate;
   tgzc_event_type cand_event;
   logic           emit;

   assign csr_ready = 1'b1;

   // Register writes; values beyond the register width are cut off.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_gap       <= MIN_GAP_RESET;
         cfg_ff.hold_time     <= HOLD_TIME_RESET;
         cfg_ff.circle_center <= CIRCLE_CENTER_RESET;
         cfg_ff.circle_radius <= CIRCLE_RADIUS_RESET;
         cfg_ff.edge_low      <= EDGE_LOW_RESET;
         cfg_ff.edge_high     <= EDGE_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MIN_GAP: begin
               cfg_ff.min_gap <= csr_wdata;
            end
            REG_HOLD_TIME: begin
               cfg_ff.hold_time <= csr_wdata;
            end
            REG_CIRCLE_CENTER: begin
               cfg_ff.circle_center <= csr_wdata[11:0];
            end
            REG_CIRCLE_RADIUS: begin
               cfg_ff.circle_radius <= csr_wdata[11:0];
            end
            REG_EDGE_LOW: begin
               cfg_ff.edge_low <= csr_wdata[11:0];
            end
            REG_EDGE_HIGH: begin
               cfg_ff.edge_high <= csr_wdata[11:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Handshake through the input and event registers. Each stage takes a new
   // item when it is empty or its current item moves on in the same cycle.
   assign s1_ready  = !s1_valid_ff || zone_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_ready = s0_ready;
   assign s0_fire   = s0_valid_ff && s1_ready;

   always_comb begin
      if (req_valid && s0_ready) begin
         s0_valid_in = 1'b1;
      end else if (s1_ready) begin
         s0_valid_in = 1'b0;
      end else begin
         s0_valid_in = s0_valid_ff;
      end

      if (s0_fire) begin
         s1_valid_in = emit;
      end else if (zone_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Gesture classification. The first matching case wins: a new touch, a
   // finger still held, a release, or nothing when no finger is involved.
   always_comb begin
      fingers_present = s0_req_ff.finger_count != 8'd0;
      multi_finger    = s0_req_ff.finger_count[7:1] != 7'd0;
      held_ms         = s0_req_ff.now_ms - press_start_time_ff;
      since_ms        = s0_req_ff.now_ms - last_dispatch_ff;
      long_due        = held_ms >= {16'd0, cfg_ff.hold_time};
      debounce_ok     = since_ms >= {16'd0, cfg_ff.min_gap};

      finger_down_in      = finger_down_ff;
      press_start_time_in = press_start_time_ff;
      press_start_x_in    = press_start_x_ff;
      press_start_y_in    = press_start_y_ff;
      long_done_in        = long_done_ff;
      candidate           = 1'b0;
      cand_event.gesture  = GEST_TAP;
      cand_event.x        = s0_req_ff.x_pos;
      cand_event.y        = s0_req_ff.y_pos;

      if (fingers_present && !finger_down_ff) begin
         // A two-finger touch is a complete gesture by itself and leaves no
         // press open.
         finger_down_in      = !multi_finger;
         press_start_time_in = s0_req_ff.now_ms;
         press_start_x_in    = s0_req_ff.x_pos;
         press_start_y_in    = s0_req_ff.y_pos;
         long_done_in        = 1'b0;
         if (multi_finger) begin
            candidate          = 1'b1;
            cand_event.gesture = GEST_TWO;
         end
      end else if (fingers_present) begin
         // The long press is marked done even if the debounce drops it, so
         // the release that follows still reports a long-press release.
         if (!long_done_ff && long_due) begin
            long_done_in       = 1'b1;
            candidate          = 1'b1;
            cand_event.gesture = GEST_LONG;
            cand_event.x       = press_start_x_ff;
            cand_event.y       = press_start_y_ff;
         end
      end else if (finger_down_ff) begin
         finger_down_in = 1'b0;
         candidate      = 1'b1;
         if (long_done_ff) begin
            cand_event.gesture = GEST_LONG_REL;
            cand_event.x       = press_start_x_ff;
            cand_event.y       = press_start_y_ff;
         end else begin
            case (s0_req_ff.gesture_code)
               CODE_DOUBLE: begin
                  cand_event.gesture = GEST_DOUBLE;
               end
               CODE_UP: begin
                  cand_event.gesture = GEST_UP;
               end
               CODE_DOWN: begin
                  cand_event.gesture = GEST_DOWN;
               end
               default: begin
                  cand_event.gesture = GEST_TAP;
               end
            endcase
         end
      end

      // Long-press release bypasses the debounce window.
      emit = candidate && (cand_event.gesture == GEST_LONG_REL || debounce_ok);
      last_dispatch_in = emit ? s0_req_ff.now_ms : last_dispatch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff         <= 1'b0;
         s1_valid_ff         <= 1'b0;
         finger_down_ff      <= 1'b0;
         press_start_time_ff <= 32'd0;
         press_start_x_ff    <= 12'd0;
         press_start_y_ff    <= 12'd0;
         long_done_ff        <= 1'b0;
         last_dispatch_ff    <= 32'd0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         if (s0_fire) begin
            finger_down_ff      <= finger_down_in;
            press_start_time_ff <= press_start_time_in;
            press_start_x_ff    <= press_start_x_in;
            press_start_y_ff    <= press_start_y_in;
            long_done_ff        <= long_done_in;
            last_dispatch_ff    <= last_dispatch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s0_ready) begin
         s0_req_ff <= req_data;
      end
      if (s0_fire) begin
         s1_event_ff <= cand_event;
      end
   end

   tgzc_zone u_zone (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid_ff),
      .in_ready  (zone_ready),
      .in_event  (s1_event_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_data)
   );

   // A two-finger touch never leaves a press open.
   a_two_finger_closes : assert property (@(posedge clock) disable iff (reset)
      s0_fire && !finger_down_ff && multi_finger |=> !finger_down_ff)
      else $error("two-finger touch left a press open");

   // A long press can only be marked while a finger is held.
   a_long_needs_press : assert property (@(posedge clock) disable iff (reset)
      $rose(long_done_ff) |-> finger_down_ff)
      else $error("long press marked without a held finger");

   // The dispatch time moves only when an event is emitted.
   a_dispatch_time : assert property (@(posedge clock) disable iff (reset)
      !(s0_fire && emit) |=> $stable(last_dispatch_ff))
      else $error("dispatch time changed without an event");

   // A new touch records its start time.
   a_start_time : assert property (@(posedge clock) disable iff (reset)
      s0_fire && fingers_present && !finger_down_ff
      |=> press_start_time_ff == $past(s0_req_ff.now_ms))
      else $error("press start time not recorded");

endmodule

// ===== rtl/core/tgzc_zone.sv =====
// Two-stage zone: squaring, then circle test and edge bands; one event per cycle unless held.
module tgzc_zone import tgzc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  tgzc_cfg_type   cfg,
   input  logic           in_valid,
   output logic           in_ready,
   input  tgzc_event_type in_event,
   output logic           out_valid,
   input  logic           out_ready,
   output tgzc_rsp_type   out_rsp
);

   // Square stage.
   logic           sq_valid_ff;
   logic           sq_valid_in;
   tgzc_event_type sq_event_ff;
   logic [23:0]    dx_sq_ff;
   logic [23:0]    dx_sq_in;
   logic [23:0]    dy_sq_ff;
   logic [23:0]    dy_sq_in;
   logic [23:0]    r_sq_ff;
   logic [23:0]    r_sq_in;
   logic           sq_ready;

   // Output stage.
   logic           out_valid_ff;
   logic           out_valid_in;
   tgzc_rsp_type   out_rsp_ff;
   tgzc_rsp_type   out_rsp_in;
   logic           out_stage_ready;

   logic [12:0]    dx;
   logic [12:0]    dy;
   logic [12:0]    dx_neg;
   logic [12:0]    dy_neg;
   logic [11:0]    dx_abs;
   logic [11:0]    dy_abs;
   logic [24:0]    dist_sq;
   logic           outside;

   assign out_stage_ready = !out_valid_ff || out_ready;
   assign sq_ready        = !sq_valid_ff || out_stage_ready;
   assign in_ready        = sq_ready;

   // Distances are squared as magnitudes, so each product is 12 by 12 bits.
   always_comb begin
      dx     = {1'b0, in_event.x} - {1'b0, cfg.circle_center};
      dy     = {1'b0, in_event.y} - {1'b0, cfg.circle_center};
      dx_neg = 13'd0 - dx;
      dy_neg = 13'd0 - dy;
      dx_abs = dx[12] ? dx_neg[11:0] : dx[11:0];
      dy_abs = dy[12] ? dy_neg[11:0] : dy[11:0];
      dx_sq_in = {12'd0, dx_abs} * {12'd0, dx_abs};
      dy_sq_in = {12'd0, dy_abs} * {12'd0, dy_abs};
      r_sq_in  = {12'd0, cfg.circle_radius} * {12'd0, cfg.circle_radius};

      if (in_valid && sq_ready) begin
         sq_valid_in = 1'b1;
      end else if (out_stage_ready) begin
         sq_valid_in = 1'b0;
      end else begin
         sq_valid_in = sq_valid_ff;
      end
   end

   always_comb begin
      dist_sq = {1'b0, dx_sq_ff} + {1'b0, dy_sq_ff};
      outside = dist_sq > {1'b0, r_sq_ff};

      out_rsp_in.event_gesture = sq_event_ff.gesture;
      out_rsp_in.event_x       = sq_event_ff.x;
      out_rsp_in.event_y       = sq_event_ff.y;
      if (outside) begin
         out_rsp_in.event_zone = ZONE_OUTSIDE;
      end else if (sq_event_ff.y < cfg.edge_low) begin
         out_rsp_in.event_zone = ZONE_TOP;
      end else if (sq_event_ff.y > cfg.edge_high) begin
         out_rsp_in.event_zone = ZONE_BOTTOM;
      end else if (sq_event_ff.x < cfg.edge_low) begin
         out_rsp_in.event_zone = ZONE_LEFT;
      end else if (sq_event_ff.x > cfg.edge_high) begin
         out_rsp_in.event_zone = ZONE_RIGHT;
      end else begin
         out_rsp_in.event_zone = ZONE_FACE;
      end

      if (sq_valid_ff && out_stage_ready) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= sq_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && sq_ready) begin
         sq_event_ff <= in_event;
         dx_sq_ff    <= dx_sq_in;
         dy_sq_ff    <= dy_sq_in;
         r_sq_ff     <= r_sq_in;
      end
      if (sq_valid_ff && out_stage_ready) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

endmodule
